/* src/svm_pkg.sv */
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants for the sixteen-bit VM core
// Control word between sequencer and datapath, status back, and helpers.
// ----------------------------------------------------------------------------
package svm_pkg;

   // command codes on req_cmd
   localparam logic [1:0] CMD_STEP = 2'd0;
   localparam logic [1:0] CMD_HWR  = 2'd1;
   localparam logic [1:0] CMD_HRD  = 2'd2;

   // fixed addresses and flag positions
   localparam logic [15:0] VEC_BASE = 16'hFFF0;
   localparam logic [15:0] SP_INIT  = 16'hFFF0;
   localparam int          FL_IE    = 15;

   // addressing modes in bits 7:6 of the mode byte
   localparam logic [1:0]  MODE_ABS = 2'd0;
   localparam logic [1:0]  MODE_R6  = 2'd1;
   localparam logic [1:0]  MODE_R7  = 2'd2;
   localparam logic [1:0]  MODE_IMM = 2'd3;

   // opcode class values in bits 7:6
   localparam logic [1:0] OP_0 = 2'd0;
   localparam logic [1:0] OP_1 = 2'd1;
   localparam logic [1:0] OP_2 = 2'd2;
   localparam logic [1:0] OP_3 = 2'd3;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_UNA = 2'd1,
      ST_ILL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MEM_NONE,
      MEM_READ,
      MEM_WRITE
   } mem_type;

   typedef enum logic [2:0] {
      AS_IP, AS_SP, AS_SP1, AS_EA, AS_EA1, AS_VEC, AS_VEC1, AS_HOST
   } asel_type;

   typedef enum logic [2:0] {
      WS_FL_LO, WS_FL_HI, WS_IP_LO, WS_IP_HI, WS_RS_LO, WS_RS_HI, WS_HOST
   } wsel_type;

   typedef enum logic [2:0] {
      CAP_NONE, CAP_OPB, CAP_MB, CAP_LO, CAP_HI
   } cap_type;

   typedef enum logic [4:0] {
      ACT_NONE, ACT_ACCEPT, ACT_SPFIX, ACT_SP_DEC2, ACT_CLR_IE, ACT_IP_INC,
      ACT_IP_WQ, ACT_IP_TMP, ACT_RET_IP, ACT_RET_FL, ACT_JCC, ACT_PRE,
      ACT_EA, ACT_POST, ACT_LOAD, ACT_LEA, ACT_IMM, ACT_SHIFT, ACT_UNARY,
      ACT_ALU, ACT_HOSTCAP
   } act_type;

   // one micro-step: memory access, byte capture and register action
   typedef struct packed {
      mem_type  mem;
      asel_type asel;
      wsel_type wsel;
      cap_type  cap;
      act_type  act;
   } ctl_type;

   // what the sequencer needs to see of the datapath
   typedef struct packed {
      logic [7:0] opb;
      logic [7:0] mb;
      logic       sp_odd;
      logic       ie;
      logic       irq_valid;
      logic       ea_odd;
   } sts_type;

   // N Z P update, interrupt enable kept
   function automatic logic [15:0] put_nzp(input logic [15:0] fl, input logic [15:0] r);
      logic [2:0] k;
      if (r == 16'h0000)
         k = 3'b010;
      else if (r[15])
         k = 3'b100;
      else
         k = 3'b001;
      return {fl[FL_IE], 12'h000, k};
   endfunction

   // logical and arithmetic shifts, counts of 16 and up saturate
   function automatic logic [15:0] shift16(input logic [15:0] x, input logic [4:0] cnt,
                                           input logic right, input logic arith);
      logic        fill;
      logic [15:0] r;
      fill = arith & x[15];
      if (cnt[4])
         r = right ? {16{fill}} : 16'h0000;
      else if (!right)
         r = x << cnt[3:0];
      else if (arith)
         r = 16'($signed(x) >>> cnt[3:0]);
      else
         r = x >> cnt[3:0];
      return r;
   endfunction

endpackage

/* src/svm_ram.sv */
// ----------------------------------------------------------------------------
// svm_ram: generic single-port RAM
// One read or write a cycle, read data registered.
// ----------------------------------------------------------------------------
module svm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* src/svm_datapath.sv */
// ----------------------------------------------------------------------------
// svm_datapath: registers, flags, address unit, ALU and byte memory
// Carries out one micro-step a cycle as told by the sequencer.
// ----------------------------------------------------------------------------
module svm_datapath (
   input  logic               clock,
   input  logic               reset,
   input  svm_pkg::ctl_type   ctl,
   input  logic               irq_valid,
   input  logic [2:0]         irq_number,
   input  logic [15:0]        mem_addr,
   input  logic [7:0]         mem_data,
   output svm_pkg::sts_type   sts,
   output logic [15:0]        next_ip,
   output logic [15:0]        stack_ptr,
   output logic [15:0]        flags_out,
   output logic [7:0]         read_byte
);

   logic [15:0] regs_ff [8];
   logic [15:0] regs_in [8];
   logic [15:0] flags_ff, flags_in;
   logic [7:0]  hbyte_ff, hbyte_in;
   logic [7:0]  opb_ff, opb_in;
   logic [7:0]  mb_ff, mb_in;
   logic [15:0] tmp_ff, tmp_in;
   logic [15:0] ea_ff, ea_in;
   logic [15:0] haddr_ff, haddr_in;
   logic [7:0]  hdata_ff, hdata_in;
   logic [2:0]  irqn_ff, irqn_in;
   logic        irqv_ff, irqv_in;

   logic [15:0] ram_addr;
   logic [7:0]  ram_wdata, ram_q;
   logic        ram_we, ram_re;

   logic [1:0]  op;
   logic [2:0]  rd, rs, rn;
   logic [15:0] sz, wq, base, res, vec, rs_val;
   logic [4:0]  cnt;

   // instruction fields
   assign op     = opb_ff[7:6];
   assign rd     = opb_ff[5:3];
   assign rs     = opb_ff[2:0];
   assign rn     = mb_ff[2:0];
   assign sz     = mb_ff[5] ? 16'd2 : 16'd1;
   assign wq     = {ram_q, tmp_ff[7:0]};
   assign vec    = svm_pkg::VEC_BASE + {12'h000, irqn_ff, 1'b0};
   assign rs_val = regs_ff[rs];
   assign cnt    = mb_ff[5] ? regs_ff[mb_ff[2:0]][4:0] : mb_ff[4:0];

   // base register for the address modes
   always_comb begin
      unique case (mb_ff[7:6])
         svm_pkg::MODE_ABS: base = 16'h0000;
         svm_pkg::MODE_R6:  base = regs_ff[6];
         svm_pkg::MODE_R7:  base = regs_ff[7];
         default:           base = tmp_ff;
      endcase
   end

   // result of register operations that set N Z P
   always_comb begin
      res = regs_ff[rd];
      unique case (ctl.act)
         svm_pkg::ACT_IMM:   res = tmp_ff;
         svm_pkg::ACT_SHIFT: res = svm_pkg::shift16(regs_ff[rd], cnt, mb_ff[7], mb_ff[6]);
         svm_pkg::ACT_UNARY: res = (op == svm_pkg::OP_2) ? ~regs_ff[rd] : 16'(16'h0 - regs_ff[rd]);
         svm_pkg::ACT_ALU: begin
            unique case (op)
               svm_pkg::OP_0: res = rs_val;
               svm_pkg::OP_1: res = regs_ff[rd] + rs_val;
               svm_pkg::OP_2: res = regs_ff[rd] & rs_val;
               default:       res = regs_ff[rd] ^ rs_val;
            endcase
         end
         default: res = regs_ff[rd];
      endcase
   end

   // memory address and write data
   always_comb begin
      unique case (ctl.asel)
         svm_pkg::AS_IP:   ram_addr = regs_ff[0];
         svm_pkg::AS_SP:   ram_addr = regs_ff[7];
         svm_pkg::AS_SP1:  ram_addr = regs_ff[7] + 16'd1;
         svm_pkg::AS_EA:   ram_addr = ea_ff;
         svm_pkg::AS_EA1:  ram_addr = ea_ff + 16'd1;
         svm_pkg::AS_VEC:  ram_addr = vec;
         svm_pkg::AS_VEC1: ram_addr = vec + 16'd1;
         default:          ram_addr = haddr_ff;
      endcase
      unique case (ctl.wsel)
         svm_pkg::WS_FL_LO: ram_wdata = flags_ff[7:0];
         svm_pkg::WS_FL_HI: ram_wdata = flags_ff[15:8];
         svm_pkg::WS_IP_LO: ram_wdata = regs_ff[0][7:0];
         svm_pkg::WS_IP_HI: ram_wdata = regs_ff[0][15:8];
         svm_pkg::WS_RS_LO: ram_wdata = rs_val[7:0];
         svm_pkg::WS_RS_HI: ram_wdata = rs_val[15:8];
         default:           ram_wdata = hdata_ff;
      endcase
   end

   assign ram_we = (ctl.mem == svm_pkg::MEM_WRITE);
   assign ram_re = (ctl.mem == svm_pkg::MEM_READ);

   svm_ram #(
      .WIDTH (8),
      .DEPTH (65536)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_q)
   );

   // next state of registers
   always_comb begin
      regs_in  = regs_ff;
      flags_in = flags_ff;
      hbyte_in = hbyte_ff;
      opb_in   = opb_ff;
      mb_in    = mb_ff;
      tmp_in   = tmp_ff;
      ea_in    = ea_ff;
      haddr_in = haddr_ff;
      hdata_in = hdata_ff;
      irqn_in  = irqn_ff;
      irqv_in  = irqv_ff;

      unique case (ctl.cap)
         svm_pkg::CAP_OPB: opb_in = ram_q;
         svm_pkg::CAP_MB:  mb_in = ram_q;
         svm_pkg::CAP_LO:  tmp_in[7:0] = ram_q;
         svm_pkg::CAP_HI:  tmp_in[15:8] = ram_q;
         default: ;
      endcase

      unique case (ctl.act)
         svm_pkg::ACT_ACCEPT: begin
            haddr_in = mem_addr;
            hdata_in = mem_data;
            irqn_in  = irq_number;
            irqv_in  = irq_valid;
            hbyte_in = 8'h00;
         end
         svm_pkg::ACT_SPFIX: begin
            if (regs_ff[7] == 16'h0000) regs_in[7] = svm_pkg::SP_INIT;
         end
         svm_pkg::ACT_SP_DEC2: regs_in[7] = regs_ff[7] - 16'd2;
         svm_pkg::ACT_CLR_IE:  flags_in[svm_pkg::FL_IE] = 1'b0;
         svm_pkg::ACT_IP_INC:  regs_in[0] = regs_ff[0] + 16'd1;
         svm_pkg::ACT_IP_WQ:   regs_in[0] = wq;
         svm_pkg::ACT_IP_TMP:  regs_in[0] = tmp_ff;
         svm_pkg::ACT_RET_IP: begin
            regs_in[0] = wq;
            regs_in[7] = regs_ff[7] + 16'd2;
         end
         svm_pkg::ACT_RET_FL: begin
            flags_in   = wq;
            regs_in[7] = regs_ff[7] + 16'd2;
         end
         svm_pkg::ACT_JCC: begin
            if ((ram_q[7:5] & flags_ff[2:0]) != 3'b000)
               regs_in[0] = regs_ff[0] + {{11{ram_q[4]}}, ram_q[4:0]};
         end
         svm_pkg::ACT_PRE: begin
            if (mb_ff[3]) regs_in[rn] = regs_ff[rn] - sz;
         end
         svm_pkg::ACT_EA: ea_in = base + regs_ff[rn];
         svm_pkg::ACT_POST: begin
            if (mb_ff[4]) regs_in[rn] = regs_ff[rn] + sz;
         end
         svm_pkg::ACT_LOAD: regs_in[rs] = mb_ff[5] ? wq : {8'h00, ram_q};
         svm_pkg::ACT_LEA:  regs_in[rs] = ea_ff;
         svm_pkg::ACT_IMM, svm_pkg::ACT_SHIFT, svm_pkg::ACT_UNARY, svm_pkg::ACT_ALU: begin
            regs_in[rd] = res;
            flags_in    = svm_pkg::put_nzp(flags_ff, res);
         end
         svm_pkg::ACT_HOSTCAP: hbyte_in = ram_q;
         default: ;
      endcase
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) regs_ff[i] <= 16'h0000;
         flags_ff <= 16'h0000;
         hbyte_ff <= 8'h00;
      end else begin
         regs_ff  <= regs_in;
         flags_ff <= flags_in;
         hbyte_ff <= hbyte_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      opb_ff   <= opb_in;
      mb_ff    <= mb_in;
      tmp_ff   <= tmp_in;
      ea_ff    <= ea_in;
      haddr_ff <= haddr_in;
      hdata_ff <= hdata_in;
      irqn_ff  <= irqn_in;
      irqv_ff  <= irqv_in;
   end

   assign sts.opb       = opb_ff;
   assign sts.mb        = mb_ff;
   assign sts.sp_odd    = regs_ff[7][0];
   assign sts.ie        = flags_ff[svm_pkg::FL_IE];
   assign sts.irq_valid = irqv_ff;
   assign sts.ea_odd    = ea_ff[0];

   assign next_ip   = regs_ff[0];
   assign stack_ptr = regs_ff[7];
   assign flags_out = flags_ff;
   assign read_byte = hbyte_ff;

endmodule

/* src/svm_ctrl.sv */
// ----------------------------------------------------------------------------
// svm_ctrl: sequencer for the sixteen-bit VM core
// Walks each command through its micro-steps and reports the outcome.
// ----------------------------------------------------------------------------
module svm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         cmd,
   input  svm_pkg::sts_type   sts,
   output svm_pkg::ctl_type   ctl,
   output logic               busy,
   output logic               done,
   output logic [1:0]         status
);

   typedef enum logic [5:0] {
      S_IDLE, S_HWR, S_HRD, S_HCAP, S_HNOP, S_SPFIX, S_F0, S_F1, S_DEC,
      S_I1, S_I2, S_I3, S_I4, S_I5, S_I6, S_I7, S_I8,
      S_R1, S_R2, S_R3, S_R4, S_R5, S_R6,
      S_J1, S_J2, S_W1, S_W2, S_W3, S_W4,
      S_C1, S_C2, S_C3, S_C4,
      S_M1, S_M2, S_M3, S_EA, S_POST, S_OP, S_L1, S_L2, S_T1,
      S_S1, S_S2, S_S3
   } state_type;

   state_type            state_ff, state_in;
   logic                 done_ff, fin;
   svm_pkg::status_type  status_ff, fin_st;
   logic [1:0]           op;
   logic [2:0]           rd, rs;

   assign op = sts.opb[7:6];
   assign rd = sts.opb[5:3];
   assign rs = sts.opb[2:0];

   // micro-step selection
   always_comb begin
      ctl      = '{svm_pkg::MEM_NONE, svm_pkg::AS_IP, svm_pkg::WS_HOST,
                   svm_pkg::CAP_NONE, svm_pkg::ACT_NONE};
      state_in = state_ff;
      fin      = 1'b0;
      fin_st   = svm_pkg::ST_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.act = svm_pkg::ACT_ACCEPT;
               priority case (cmd)
                  svm_pkg::CMD_STEP: state_in = S_SPFIX;
                  svm_pkg::CMD_HWR:  state_in = S_HWR;
                  svm_pkg::CMD_HRD:  state_in = S_HRD;
                  default:           state_in = S_HNOP;
               endcase
            end
         end
         S_HWR: begin
            ctl.mem  = svm_pkg::MEM_WRITE;
            ctl.asel = svm_pkg::AS_HOST;
            ctl.wsel = svm_pkg::WS_HOST;
            fin      = 1'b1;
         end
         S_HRD: begin
            ctl.mem  = svm_pkg::MEM_READ;
            ctl.asel = svm_pkg::AS_HOST;
            state_in = S_HCAP;
         end
         S_HCAP: begin
            ctl.act = svm_pkg::ACT_HOSTCAP;
            fin     = 1'b1;
         end
         S_HNOP: fin = 1'b1;

         // stack pointer fix-up and interrupt decision
         S_SPFIX: begin
            ctl.act = svm_pkg::ACT_SPFIX;
            if (sts.irq_valid && sts.ie) begin
               if (sts.sp_odd) begin
                  fin    = 1'b1;
                  fin_st = svm_pkg::ST_UNA;
               end else begin
                  state_in = S_I1;
               end
            end else begin
               state_in = S_F0;
            end
         end

         // interrupt entry: push flags, push IP, load vector
         S_I1: begin
            ctl.act  = svm_pkg::ACT_SP_DEC2;
            state_in = S_I2;
         end
         S_I2: begin
            ctl.mem  = svm_pkg::MEM_WRITE;
            ctl.asel = svm_pkg::AS_SP;
            ctl.wsel = svm_pkg::WS_FL_LO;
            state_in = S_I3;
         end
         S_I3: begin
            ctl.mem  = svm_pkg::MEM_WRITE;
            ctl.asel = svm_pkg::AS_SP1;
            ctl.wsel = svm_pkg::WS_FL_HI;
            ctl.act  = svm_pkg::ACT_SP_DEC2;
            state_in = S_I4;
         end
         S_I4: begin
            ctl.mem  = svm_pkg::MEM_WRITE;
            ctl.asel = svm_pkg::AS_SP;
            ctl.wsel = svm_pkg::WS_IP_LO;
            state_in = S_I5;
         end
         S_I5: begin
            ctl.mem  = svm_pkg::MEM_WRITE;
            ctl.asel = svm_pkg::AS_SP1;
            ctl.wsel = svm_pkg::WS_IP_HI;
            ctl.act  = svm_pkg::ACT_CLR_IE;
            state_in = S_I6;
         end
         S_I6: begin
            ctl.mem  = svm_pkg::MEM_READ;
            ctl.asel = svm_pkg::AS_VEC;
            state_in = S_I7;
         end
         S_I7: begin
            ctl.mem  = svm_pkg::MEM_READ;
            ctl.asel = svm_pkg::AS_VEC1;
            ctl.cap  = svm_pkg::CAP_LO;
            state_in = S_I8;
         end
         S_I8: begin
            ctl.act = svm_pkg::ACT_IP_WQ;
            fin     = 1'b1;
         end

         // opcode fetch
         S_F0: begin
            ctl.mem  = svm_pkg::MEM_READ;
            ctl.asel = svm_pkg::AS_IP;
            ctl.act  = svm_pkg::ACT_IP_INC;
            state_in = S_F1;
         end
         S_F1: begin
            ctl.cap  = svm_pkg::CAP_OPB;
            state_in = S_DEC;
         end

         // decode
         S_DEC: begin
            if (rd == 3'd0) begin
               if (rs == 3'd0) begin
                  unique case (op)
                     svm_pkg::OP_0: begin
                        if (sts.sp_odd) begin
                           fin    = 1'b1;
                           fin_st = svm_pkg::ST_UNA;
                        end else begin
                           state_in = S_R1;
                        end
                     end
                     svm_pkg::OP_1: state_in = S_J1;
                     default:       state_in = S_W1;
                  endcase
               end else if (op == svm_pkg::OP_3) begin
                  fin    = 1'b1;
                  fin_st = svm_pkg::ST_ILL;
               end else begin
                  state_in = S_M1;
               end
            end else if (rs == 3'd0) begin
               unique case (op)
                  svm_pkg::OP_0: state_in = S_W1;
                  svm_pkg::OP_1: state_in = S_S1;
                  default: begin
                     ctl.act = svm_pkg::ACT_UNARY;
                     fin     = 1'b1;
                  end
               endcase
            end else begin
               ctl.act = svm_pkg::ACT_ALU;
               fin     = 1'b1;
            end
         end

         // return: pop IP, and flags when interrupts are off
         S_R1: begin
            ctl.mem  = svm_pkg::MEM_READ;
            ctl.asel = svm_pkg::AS_SP;
            state_in = S_R2;
         end
         S_R2: begin
            ctl.mem  = svm_pkg::MEM_READ;
            ctl.asel = svm_pkg::AS_SP1;
            ctl.cap  = svm_pkg::CAP_LO;
            state_in = S_R3;
         end
         S_R3: begin
            ctl.act = svm_pkg::ACT_RET_IP;
            if (sts.ie) fin = 1'b1;
            else state_in = S_R4;
         end
         S_R4: begin
            ctl.mem  = svm_pkg::MEM_READ;
            ctl.asel = svm_pkg::AS_SP;
            state_in = S_R5;
         end
         S_R5: begin
            ctl.mem  = svm_pkg::MEM_READ;
            ctl.asel = svm_pkg::AS_SP1;
            ctl.cap  = svm_pkg::CAP_LO;
            state_in = S_R6;
         end
         S_R6: begin
            ctl.act = svm_pkg::ACT_RET_FL;
            fin     = 1'b1;
         end

         // conditional relative jump
         S_J1: begin
            ctl.mem  = svm_pkg::MEM_READ;
            ctl.asel = svm_pkg::AS_IP;
            ctl.act  = svm_pkg::ACT_IP_INC;
            state_in = S_J2;
         end
         S_J2: begin
            ctl.act = svm_pkg::ACT_JCC;
            fin     = 1'b1;
         end

         // inline word fetch, shared by jump, call, immediate and base mode
         S_W1: begin
            ctl.mem  = svm_pkg::MEM_READ;
            ctl.asel = svm_pkg::AS_IP;
            ctl.act  = svm_pkg::ACT_IP_INC;
            state_in = S_W2;
         end
         S_W2: begin
            ctl.mem  = svm_pkg::MEM_READ;
            ctl.asel = svm_pkg::AS_IP;
            ctl.act  = svm_pkg::ACT_IP_INC;
            ctl.cap  = svm_pkg::CAP_LO;
            state_in = S_W3;
         end
         S_W3: begin
            ctl.cap  = svm_pkg::CAP_HI;
            state_in = S_W4;
         end
         S_W4: begin
            if (rd != 3'd0) begin
               ctl.act = svm_pkg::ACT_IMM;
               fin     = 1'b1;
            end else if (rs != 3'd0) begin
               state_in = S_EA;
            end else if (op == svm_pkg::OP_2) begin
               ctl.act = svm_pkg::ACT_IP_TMP;
               fin     = 1'b1;
            end else if (sts.sp_odd) begin
               fin    = 1'b1;
               fin_st = svm_pkg::ST_UNA;
            end else begin
               state_in = S_C1;
            end
         end

         // call: push IP, jump
         S_C1: begin
            ctl.act  = svm_pkg::ACT_SP_DEC2;
            state_in = S_C2;
         end
         S_C2: begin
            ctl.mem  = svm_pkg::MEM_WRITE;
            ctl.asel = svm_pkg::AS_SP;
            ctl.wsel = svm_pkg::WS_IP_LO;
            state_in = S_C3;
         end
         S_C3: begin
            ctl.mem  = svm_pkg::MEM_WRITE;
            ctl.asel = svm_pkg::AS_SP1;
            ctl.wsel = svm_pkg::WS_IP_HI;
            state_in = S_C4;
         end
         S_C4: begin
            ctl.act = svm_pkg::ACT_IP_TMP;
            fin     = 1'b1;
         end

         // memory operand: mode byte, pre-decrement, address, post-increment
         S_M1: begin
            ctl.mem  = svm_pkg::MEM_READ;
            ctl.asel = svm_pkg::AS_IP;
            ctl.act  = svm_pkg::ACT_IP_INC;
            state_in = S_M2;
         end
         S_M2: begin
            ctl.cap  = svm_pkg::CAP_MB;
            state_in = S_M3;
         end
         S_M3: begin
            ctl.act = svm_pkg::ACT_PRE;
            if (sts.mb[7:6] == svm_pkg::MODE_IMM) state_in = S_W1;
            else state_in = S_EA;
         end
         S_EA: begin
            ctl.act  = svm_pkg::ACT_EA;
            state_in = S_POST;
         end
         S_POST: begin
            ctl.act  = svm_pkg::ACT_POST;
            state_in = S_OP;
         end
         S_OP: begin
            if (sts.mb[5] && sts.ea_odd && op != svm_pkg::OP_2) begin
               fin    = 1'b1;
               fin_st = svm_pkg::ST_UNA;
            end else begin
               unique case (op)
                  svm_pkg::OP_0: begin
                     ctl.mem  = svm_pkg::MEM_READ;
                     ctl.asel = svm_pkg::AS_EA;
                     state_in = S_L1;
                  end
                  svm_pkg::OP_1: begin
                     ctl.mem  = svm_pkg::MEM_WRITE;
                     ctl.asel = svm_pkg::AS_EA;
                     ctl.wsel = svm_pkg::WS_RS_LO;
                     if (sts.mb[5]) state_in = S_T1;
                     else fin = 1'b1;
                  end
                  default: begin
                     ctl.act = svm_pkg::ACT_LEA;
                     fin     = 1'b1;
                  end
               endcase
            end
         end
         S_L1: begin
            if (sts.mb[5]) begin
               ctl.mem  = svm_pkg::MEM_READ;
               ctl.asel = svm_pkg::AS_EA1;
               ctl.cap  = svm_pkg::CAP_LO;
               state_in = S_L2;
            end else begin
               ctl.act = svm_pkg::ACT_LOAD;
               fin     = 1'b1;
            end
         end
         S_L2: begin
            ctl.act = svm_pkg::ACT_LOAD;
            fin     = 1'b1;
         end
         S_T1: begin
            ctl.mem  = svm_pkg::MEM_WRITE;
            ctl.asel = svm_pkg::AS_EA1;
            ctl.wsel = svm_pkg::WS_RS_HI;
            fin      = 1'b1;
         end

         // shift: control byte, then shift
         S_S1: begin
            ctl.mem  = svm_pkg::MEM_READ;
            ctl.asel = svm_pkg::AS_IP;
            ctl.act  = svm_pkg::ACT_IP_INC;
            state_in = S_S2;
         end
         S_S2: begin
            ctl.cap  = svm_pkg::CAP_MB;
            state_in = S_S3;
         end
         S_S3: begin
            fin = 1'b1;
            if (sts.mb[5] && sts.mb[4:3] != 2'b00) fin_st = svm_pkg::ST_ILL;
            else ctl.act = svm_pkg::ACT_SHIFT;
         end
         default: state_in = S_IDLE;
      endcase

      if (fin) state_in = S_IDLE;
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         done_ff   <= 1'b0;
         status_ff <= svm_pkg::ST_OK;
      end else begin
         state_ff  <= state_in;
         done_ff   <= fin;
         status_ff <= fin_st;
      end
   end

   assign busy   = (state_ff != S_IDLE);
   assign done   = done_ff;
   assign status = status_ff;

endmodule

/* src/sixteen_bit_vm_core.sv */
// ----------------------------------------------------------------------------
// sixteen_bit_vm_core: sixteen-bit VM core with byte memory
// Sequencer plus datapath; runs one instruction, interrupt or host access
// per command word.
// ----------------------------------------------------------------------------
//  channel   handshake         word
//  request   start / busy      req_cmd, req_irq_*, req_mem_addr, req_mem_data
//  response  rsp_valid strobe  rsp_status, rsp_next_ip, rsp_stack_ptr,
//                              rsp_flags_out, rsp_read_byte
//
//  A command word runs as a sequence of micro-steps from accept to rsp_valid
//  over the single byte-wide memory port, one byte per cycle with registered
//  read. busy is high from the cycle after accept until rsp_valid; a new
//  command may be started in the rsp_valid cycle. Reset clears registers and
//  flags; memory is left as is. The receiver cannot stall.
// ----------------------------------------------------------------------------
module sixteen_bit_vm_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic        req_irq_valid,
   input  logic [2:0]  req_irq_number,
   input  logic [15:0] req_mem_addr,
   input  logic [7:0]  req_mem_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_next_ip,
   output logic [15:0] rsp_stack_ptr,
   output logic [15:0] rsp_flags_out,
   output logic [7:0]  rsp_read_byte
);

   svm_pkg::ctl_type ctl;
   svm_pkg::sts_type sts;

   svm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .cmd    (req_cmd),
      .sts    (sts),
      .ctl    (ctl),
      .busy   (busy),
      .done   (rsp_valid),
      .status (rsp_status)
   );

   svm_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .irq_valid  (req_irq_valid),
      .irq_number (req_irq_number),
      .mem_addr   (req_mem_addr),
      .mem_data   (req_mem_data),
      .sts        (sts),
      .next_ip    (rsp_next_ip),
      .stack_ptr  (rsp_stack_ptr),
      .flags_out  (rsp_flags_out),
      .read_byte  (rsp_read_byte)
   );

   // a response is only given once the sequencer has returned to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // an accepted command always occupies the core
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not start");

   // every response closes a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a command");

   // faults only come from steps, which never return a host byte
   a_fault_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != svm_pkg::ST_OK) |-> (rsp_read_byte == 8'h00))
      else $error("fault status with host byte");

endmodule
